[rtl/assert_macros.svh]
// assertion macros used by the port-level checks in ckbf_chk
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CKBF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ckbf check failed");

// next-cycle implication, disabled during reset
`define CKBF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ckbf check failed");

`endif

[rtl/ckbf_pkg.sv]
// types and constants for the canonical k-mer bloom filter
// no dependencies
package ckbf_pkg;

    localparam int KMER_MAX  = 32;
    localparam int FILT_BITS = 1048576;
    localparam int IDX_W     = $clog2(FILT_BITS);
    localparam int WORD_W    = 64;
    localparam int OFS_W     = $clog2(WORD_W);
    localparam int MEM_DEPTH = FILT_BITS / WORD_W;
    localparam int MEM_AW    = IDX_W - OFS_W;
    localparam int SIZE_W    = IDX_W + 1;
    localparam int K_W       = 6;

    localparam logic [1:0] CFG_KMER_LEN    = 2'd0;
    localparam logic [1:0] CFG_FILTER_SIZE = 2'd1;
    localparam logic [1:0] CFG_HASH_ROUNDS = 2'd2;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic ACT_FEED  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [7:0] CH_HDR = 8'h3E;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CH_G   = 8'h47;
    localparam logic [7:0] CH_T   = 8'h54;

    typedef struct packed {
        logic        action;
        logic [7:0]  text_byte;
        logic [63:0] query_value;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic             present;
        logic [63:0]      canonical_value;
        logic [IDX_W-1:0] bit_index;
    } t_out_beat;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic feed;
        logic seed;
        logic hash_step;
        logic div_init;
        logic div_step;
        logic mem_rd;
        logic mem_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic is_query;
        logic will_insert;
        logic rounds_done;
        logic div_done;
    } t_sts;

endpackage

[rtl/ckbf_ctrl.sv]
// controller state machine for the k-mer bloom filter
// depends on ckbf_pkg
module ckbf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    input  ckbf_pkg::t_sts i_sts,
    output ckbf_pkg::t_cmd o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DEC, S_SEED, S_HASH, S_DIV, S_RD, S_WR, S_LOAD, S_OUT
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.clr_wr    = (r_state == S_CLEAR);
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.feed      = (r_state == S_DEC) && !i_sts.is_query;
        o_cmd.seed      = (r_state == S_SEED);
        o_cmd.hash_step = (r_state == S_HASH) && !i_sts.rounds_done;
        o_cmd.div_init  = (r_state == S_HASH) && i_sts.rounds_done;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.mem_rd    = (r_state == S_RD);
        o_cmd.mem_wr    = (r_state == S_WR);
        o_cmd.out_load  = (r_state == S_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_in_stall  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (i_sts.clear_last) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_DEC;
                        r_in_stall <= 1'b1;
                    end
                end
                S_DEC: begin
                    if (i_sts.is_query || i_sts.will_insert) begin
                        r_state <= S_SEED;
                    end else begin
                        r_state <= S_LOAD;
                    end
                end
                S_SEED: r_state <= S_HASH;
                S_HASH: begin
                    if (i_sts.rounds_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_WR;
                S_WR: r_state <= S_LOAD;
                S_LOAD: begin
                    r_state     <= S_OUT;
                    r_out_valid <= 1'b1;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_stall  <= 1'b0;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                    r_in_stall  <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule

[rtl/ckbf_dp.sv]
// datapath: config, base window, canonical pick, xorshift, serial modulo, bit memory
// depends on ckbf_pkg
module ckbf_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ckbf_pkg::t_cmd       i_cmd,
    output ckbf_pkg::t_sts       o_sts,
    input  ckbf_pkg::t_in_beat   i_in_data,
    output ckbf_pkg::t_out_beat  o_out_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [ckbf_pkg::SIZE_W-1:0] i_cfg_data
);

    logic [ckbf_pkg::K_W-1:0]    r_kmer_len;
    logic [ckbf_pkg::SIZE_W-1:0] r_fsize;
    logic [7:0]                  r_rounds;

    logic        r_action;
    logic [7:0]  r_byte;
    logic [63:0] r_qval;

    logic [63:0]                 r_win;
    logic [ckbf_pkg::K_W-1:0]    r_held;
    logic                        r_in_hdr;
    logic                        r_ins;
    logic [63:0]                 r_canon;
    logic [63:0]                 r_hv;
    logic [7:0]                  r_rcnt;
    logic [ckbf_pkg::IDX_W-1:0]  r_rem;
    logic [ckbf_pkg::OFS_W-1:0]  r_dcnt;
    logic [ckbf_pkg::MEM_AW-1:0] r_clr_addr;
    logic [63:0]                 r_rdata;
    logic [63:0]                 r_mem [ckbf_pkg::MEM_DEPTH];
    ckbf_pkg::t_out_beat         r_out;

    logic [ckbf_pkg::K_W-1:0]    k;
    logic [ckbf_pkg::SIZE_W-1:0] size;
    logic                        is_base;
    logic [1:0]                  ord;
    logic [ckbf_pkg::K_W-1:0]    held_next;
    logic [ckbf_pkg::K_W-1:0]    sh;
    logic [63:0]                 fwd;
    logic [63:0]                 revc;
    logic [63:0]                 mask;
    logic [63:0]                 rv;
    logic [63:0]                 sel;
    logic [63:0]                 canon_c;
    logic [63:0]                 src;
    logic [63:0]                 x1;
    logic [63:0]                 x2;
    logic [63:0]                 x3;
    logic [ckbf_pkg::SIZE_W-1:0] trial;
    logic [ckbf_pkg::MEM_AW-1:0] waddr;
    logic [ckbf_pkg::OFS_W-1:0]  ofs;

    always_comb begin
        if (r_kmer_len == '0) begin
            k = ckbf_pkg::K_W'(1);
        end else if (r_kmer_len > ckbf_pkg::K_W'(ckbf_pkg::KMER_MAX)) begin
            k = ckbf_pkg::K_W'(ckbf_pkg::KMER_MAX);
        end else begin
            k = r_kmer_len;
        end
        if (r_fsize == '0) begin
            size = ckbf_pkg::SIZE_W'(1);
        end else if (r_fsize > ckbf_pkg::SIZE_W'(ckbf_pkg::FILT_BITS)) begin
            size = ckbf_pkg::SIZE_W'(ckbf_pkg::FILT_BITS);
        end else begin
            size = r_fsize;
        end
    end

    // lexical order code: A0 C1 G2 T3
    always_comb begin
        is_base = 1'b1;
        case (r_byte)
            ckbf_pkg::CH_A: ord = 2'd0;
            ckbf_pkg::CH_C: ord = 2'd1;
            ckbf_pkg::CH_G: ord = 2'd2;
            ckbf_pkg::CH_T: ord = 2'd3;
            default: begin
                ord     = 2'd0;
                is_base = 1'b0;
            end
        endcase
        held_next = (r_held == ckbf_pkg::K_W'(ckbf_pkg::KMER_MAX)) ? r_held
                    : r_held + ckbf_pkg::K_W'(1);
    end

    assign o_sts.is_query    = (r_action == ckbf_pkg::ACT_QUERY);
    assign o_sts.will_insert = !r_in_hdr && is_base && (held_next >= k);
    assign o_sts.rounds_done = (r_rcnt == r_rounds);
    assign o_sts.div_done    = (r_dcnt == '1);
    assign o_sts.clear_last  = (r_clr_addr == '1);

    // oldest base in the top bits, newest in the bottom
    always_comb begin
        sh   = ckbf_pkg::K_W'(ckbf_pkg::KMER_MAX) - k;
        fwd  = r_win << {sh, 1'b0};
        mask = ~({64{1'b1}} >> {k, 1'b0});
        for (int i = 0; i < ckbf_pkg::KMER_MAX; i++) begin
            revc[63-2*i -: 2] = ~r_win[2*i +: 2];
        end
        rv  = revc & mask;
        sel = (fwd > rv) ? rv : fwd;
        for (int i = 0; i < ckbf_pkg::KMER_MAX; i++) begin
            canon_c[2*i +: 2] = {sel[63-2*i], sel[63-2*i] ^ sel[62-2*i]};
        end
        src = (r_action == ckbf_pkg::ACT_QUERY) ? r_qval : canon_c;
        x1  = r_hv ^ (r_hv << 13);
        x2  = x1 ^ (x1 >> 7);
        x3  = x2 ^ (x2 << 17);
        trial = {r_rem, r_hv[63]};
        ofs   = r_rem[ckbf_pkg::OFS_W-1:0];
        waddr = i_cmd.clr_wr ? r_clr_addr : r_rem[ckbf_pkg::IDX_W-1:ckbf_pkg::OFS_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len <= ckbf_pkg::K_W'(31);
            r_fsize    <= ckbf_pkg::SIZE_W'(ckbf_pkg::FILT_BITS);
            r_rounds   <= 8'd1;
            r_win      <= '0;
            r_held     <= '0;
            r_in_hdr   <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ckbf_pkg::CFG_KMER_LEN:    r_kmer_len <= i_cfg_data[ckbf_pkg::K_W-1:0];
                    ckbf_pkg::CFG_FILTER_SIZE: r_fsize    <= i_cfg_data;
                    ckbf_pkg::CFG_HASH_ROUNDS: r_rounds   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + ckbf_pkg::MEM_AW'(1);
            end
            if (i_cmd.feed) begin
                if (r_in_hdr) begin
                    if (r_byte == ckbf_pkg::CH_LF) begin
                        r_in_hdr <= 1'b0;
                    end
                end else if (r_byte == ckbf_pkg::CH_HDR) begin
                    r_in_hdr <= 1'b1;
                end else if (is_base) begin
                    r_win  <= {r_win[61:0], ord};
                    r_held <= held_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_in_data.action;
            r_byte   <= i_in_data.text_byte;
            r_qval   <= i_in_data.query_value;
            r_ins    <= 1'b0;
        end
        if (i_cmd.feed) begin
            r_ins <= o_sts.will_insert;
        end
        if (i_cmd.seed) begin
            r_canon <= canon_c;
            r_hv    <= (src == '0) ? {64{1'b1}} : src;
            r_rcnt  <= '0;
        end
        if (i_cmd.hash_step) begin
            r_hv   <= x3;
            r_rcnt <= r_rcnt + 8'd1;
        end
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_hv   <= r_hv << 1;
            r_dcnt <= r_dcnt + ckbf_pkg::OFS_W'(1);
            if (trial >= size) begin
                r_rem <= ckbf_pkg::IDX_W'(trial - size);
            end else begin
                r_rem <= trial[ckbf_pkg::IDX_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            if (r_action == ckbf_pkg::ACT_QUERY) begin
                r_out.result_kind     <= ckbf_pkg::KIND_QUERY;
                r_out.present         <= r_rdata[ofs];
                r_out.canonical_value <= '0;
                r_out.bit_index       <= r_rem;
            end else if (r_ins) begin
                r_out.result_kind     <= ckbf_pkg::KIND_INSERT;
                r_out.present         <= 1'b0;
                r_out.canonical_value <= r_canon;
                r_out.bit_index       <= r_rem;
            end else begin
                r_out.result_kind     <= ckbf_pkg::KIND_NONE;
                r_out.present         <= 1'b0;
                r_out.canonical_value <= '0;
                r_out.bit_index       <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[r_rem[ckbf_pkg::IDX_W-1:ckbf_pkg::OFS_W]];
        end
        if (i_cmd.clr_wr) begin
            r_mem[waddr] <= '0;
        end else if (i_cmd.mem_wr && (r_action == ckbf_pkg::ACT_FEED)) begin
            r_mem[waddr] <= r_rdata | (64'd1 << ofs);
        end
    end

    assign o_out_data = r_out;

endmodule

[rtl/canonical_kmer_bloom_filter_top.sv]
// top level of the canonical k-mer bloom filter
// depends on ckbf_pkg, ckbf_ctrl, ckbf_dp
//
// channel  direction  signals
// in       input      i_in_valid, o_in_stall, i_in_data
// out      output     o_out_valid, i_out_stall, o_out_data
// cfg      input      i_cfg_we, i_cfg_idx, i_cfg_data
//
// one item at a time; a byte that inserts nothing goes from decode straight to the result load
// an insert or query runs hash_rounds xorshift rounds, one xorshift round per cycle,
// then a bit-serial modulo, then a bit memory read and, for an insert, the write back
// after reset the bit memory is cleared one 64-bit word a cycle, 16384 words, with stall high
// the result beat holds until taken; a new beat is accepted the cycle after
module canonical_kmer_bloom_filter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ckbf_pkg::t_in_beat          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ckbf_pkg::t_out_beat         o_out_data,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [ckbf_pkg::SIZE_W-1:0] i_cfg_data
);

    ckbf_pkg::t_cmd cmd;
    ckbf_pkg::t_sts sts;

    ckbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    ckbf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

endmodule

[rtl/ckbf_chk.sv]
// port-level checks for the k-mer bloom filter top
// depends on ckbf_pkg, assert_macros.svh, canonical_kmer_bloom_filter_top
`include "assert_macros.svh"

module ckbf_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input ckbf_pkg::t_out_beat         o_out_data
);

    `CKBF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `CKBF_ASSERT_NOW(a_busy_when_out, o_out_valid, o_in_stall)
    `CKBF_ASSERT_NEXT(a_stall_after_accept, i_in_valid && !o_in_stall,
        o_in_stall && !o_out_valid)
    `CKBF_ASSERT_NOW(a_none_is_empty,
        o_out_valid && (o_out_data.result_kind == ckbf_pkg::KIND_NONE),
        (o_out_data.canonical_value == '0) && (o_out_data.bit_index == '0) && !o_out_data.present)

endmodule

bind canonical_kmer_bloom_filter_top ckbf_chk u_ckbf_chk (.*);

[dv/ckbf_checker.sv]
// checker for the canonical k-mer bloom filter: watches the in, out and cfg ports,
// predicts every result beat and compares it field by field
// depends on ckbf_pkg
`timescale 1ns / 100ps

module ckbf_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  ckbf_pkg::t_in_beat          i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  ckbf_pkg::t_out_beat         i_out_data,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [ckbf_pkg::SIZE_W-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_inserts,
    output int                          o_hits
);
    import ckbf_pkg::*;

    bit                filter_bits [FILT_BITS];
    logic [7:0]        base_win [KMER_MAX];
    int unsigned       held_bases;
    bit                header_on;
    logic [5:0]        k_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [7:0]        rounds_reg;
    t_out_beat         pending_answers [$];
    int                fails;
    int                inserts;
    int                hits;

    function automatic logic [IDX_W-1:0] filter_pos(logic [63:0] v);
        logic [63:0] x;
        logic [63:0] sz;
        sz = size_reg;
        if (sz == 0) sz = 1;
        if (sz > FILT_BITS) sz = FILT_BITS;
        x = (v == 0) ? '1 : v;
        for (int r = 0; r < rounds_reg; r++) begin
            x ^= x << 13;
            x ^= x >> 7;
            x ^= x << 17;
        end
        return IDX_W'(x % sz);
    endfunction

    function automatic logic [7:0] base_comp(logic [7:0] c);
        case (c)
            CH_A: return CH_T;
            CH_C: return CH_G;
            CH_G: return CH_C;
            CH_T: return CH_A;
            default: return c;
        endcase
    endfunction

    function automatic logic [63:0] base_bits(logic [7:0] c);
        case (c)
            CH_C: return 64'd1;
            CH_T: return 64'd2;
            CH_G: return 64'd3;
            default: return 64'd0;
        endcase
    endfunction

    function automatic t_out_beat filter_answer(t_in_beat b);
        t_out_beat   a;
        logic [7:0]  c;
        logic [7:0]  f;
        logic [7:0]  rc;
        int unsigned k;
        int unsigned first;
        bit          rev;
        a = '0;
        if (b.action == ACT_QUERY) begin
            a.bit_index = filter_pos(b.query_value);
            a.present = filter_bits[a.bit_index];
            a.result_kind = KIND_QUERY;
        end else begin
            c = b.text_byte;
            if (header_on) begin
                if (c == CH_LF) header_on = 0;
            end else if (c == CH_HDR) begin
                header_on = 1;
            end else if (c == CH_A || c == CH_C || c == CH_G || c == CH_T) begin
                k = k_reg;
                if (k == 0) k = 1;
                if (k > KMER_MAX) k = KMER_MAX;
                for (int i = 0; i < KMER_MAX - 1; i++) base_win[i] = base_win[i+1];
                base_win[KMER_MAX-1] = c;
                if (held_bases < KMER_MAX) held_bases++;
                if (held_bases >= k) begin
                    first = KMER_MAX - k;
                    rev = 0;
                    for (int i = 0; i < k; i++) begin
                        f = base_win[first + i];
                        rc = base_comp(base_win[first + k - 1 - i]);
                        if (f > rc) begin
                            rev = 1;
                            break;
                        end
                        if (f < rc) break;
                    end
                    for (int i = 0; i < k; i++) begin
                        f = rev ? base_comp(base_win[first + k - 1 - i]) : base_win[first + i];
                        a.canonical_value |= base_bits(f) << (2 * i);
                    end
                    a.bit_index = filter_pos(a.canonical_value);
                    filter_bits[a.bit_index] = 1;
                    a.result_kind = KIND_INSERT;
                end
            end
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            foreach (filter_bits[i]) filter_bits[i] = 0;
            foreach (base_win[i]) base_win[i] = '0;
            held_bases = 0;
            header_on = 0;
            k_reg = 6'd31;
            size_reg = SIZE_W'(FILT_BITS);
            rounds_reg = 8'd1;
            pending_answers.delete();
            fails = 0;
            inserts = 0;
            hits = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KMER_LEN:    k_reg = i_cfg_data[5:0];
                    CFG_FILTER_SIZE: size_reg = i_cfg_data;
                    CFG_HASH_ROUNDS: rounds_reg = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_answers.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result beat %p", $realtime, i_out_data);
                end else begin
                    want = pending_answers.pop_front();
                    if (i_out_data.result_kind != want.result_kind
                        || i_out_data.present != want.present
                        || i_out_data.canonical_value != want.canonical_value
                        || i_out_data.bit_index != want.bit_index) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: mismatch exp %p got %p", $realtime, want,
                                     i_out_data);
                    end
                    if (want.result_kind == KIND_INSERT) inserts++;
                    if (want.present) hits++;
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_answers.push_back(filter_answer(i_in_data));
        end
        o_fail_count <= fails;
        o_pending <= pending_answers.size();
        o_inserts <= inserts;
        o_hits <= hits;
    end

endmodule

[dv/tb_canonical_kmer_bloom_filter_top.sv]
// testbench top for the canonical k-mer bloom filter: directed and random fasta
// bytes and queries over several register settings, with random gaps and stalls
// depends on ckbf_pkg, canonical_kmer_bloom_filter_top and ckbf_checker
`timescale 1ns / 100ps

module tb_canonical_kmer_bloom_filter_top;
    import ckbf_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_beat          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_beat         o_out_data;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [SIZE_W-1:0] i_cfg_data;
    int                fail_count;
    int                pending;
    int                inserts;
    int                hits;
    int                beats_sent;
    bit                idle_on;
    bit                recv_on;

    canonical_kmer_bloom_filter_top dut (.*);

    ckbf_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_inserts    (inserts),
        .o_hits       (hits)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_beat(logic act, logic [7:0] ch, logic [63:0] qv);
        int gap;
        t_in_beat b;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        b.action = act;
        b.text_byte = ch;
        b.query_value = qv;
        i_in_valid <= 1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
    endtask

    task automatic feed(logic [7:0] ch);
        send_beat(ACT_FEED, ch, {$urandom, $urandom});
    endtask

    task automatic query(logic [63:0] qv);
        send_beat(ACT_QUERY, 8'($urandom), qv);
    endtask

    task automatic drain;
        i_in_valid <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [SIZE_W-1:0] data);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic set_regs(logic [SIZE_W-1:0] k, logic [SIZE_W-1:0] sz,
                            logic [SIZE_W-1:0] rounds);
        drain();
        write_reg(CFG_KMER_LEN, k);
        write_reg(CFG_FILTER_SIZE, sz);
        write_reg(CFG_HASH_ROUNDS, rounds);
    endtask

    task automatic random_run(int count, int k);
        int r;
        logic [7:0] acgt [4];
        logic [7:0] skips [4];
        logic [63:0] qv;
        acgt = '{CH_A, CH_C, CH_G, CH_T};
        skips = '{8'h4E, 8'h6E, 8'h0D, CH_LF};
        idle_on = $urandom_range(0, 1);
        recv_on = $urandom_range(0, 1);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                qv = {$urandom, $urandom};
                if ($urandom_range(0, 3) != 0 && k < 32) qv &= (64'd1 << (2 * k)) - 1;
                query(qv);
            end else if (r < 72) feed(acgt[$urandom_range(0, 3)]);
            else if (r < 78) feed(skips[$urandom_range(0, 3)]);
            else if (r < 83) feed(CH_HDR);
            else if (r < 92) feed(8'($urandom));
            else feed(CH_LF);
            if (n % 100 == 99) begin
                idle_on = $urandom_range(0, 1);
                recv_on = $urandom_range(0, 1);
            end
        end
    endtask

    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                n = recv_on ? $urandom_range(0, 15) : 0;
                if (n > 0) begin
                    i_out_stall <= 1;
                    repeat (n) @(posedge i_clk);
                end
                i_out_stall <= 0;
                do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
            end
        end
    end

    initial begin
        int k;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_data = '0;
        i_out_stall = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_KMER_LEN;
        i_cfg_data = '0;
        beats_sent = 0;
        idle_on = 1;
        recv_on = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // zero and all-ones queries, header bytes, skipped and unknown bytes
        query(64'd0);
        query('1);
        feed(CH_HDR);
        feed(CH_A);
        feed(CH_LF);
        feed(8'h4E);
        feed(8'h6E);
        feed(8'h0D);
        feed(CH_LF);
        feed(8'h00);
        feed(8'hFF);
        feed(8'h61);

        set_regs(3, 64, 0);
        feed(CH_A);
        feed(CH_C);
        feed(CH_G);
        feed(CH_T);
        feed(CH_T);
        feed(CH_A);
        query(64'h34);
        query(64'h0);
        // longer k after a short run: the bases already held still count, so the next base inserts
        set_regs(5, 64, 0);
        feed(CH_G);
        feed(CH_C);
        query(64'h1);

        set_regs(31, 1048576, 1);
        random_run(300, 31);
        set_regs(1, 1, 0);
        random_run(150, 1);
        set_regs(0, 0, 2);
        random_run(100, 1);
        set_regs(63, 2097151, 3);
        random_run(150, 32);
        set_regs(32, 1048576, 255);
        random_run(40, 32);
        set_regs(4, 16, 5);
        random_run(200, 4);
        for (int p = 0; p < 3; p++) begin
            k = $urandom_range(1, 32);
            set_regs(k, $urandom_range(1, 4096), $urandom_range(0, 8));
            random_run(120, k);
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("%0d input beats over the reset settings and eleven written ones", beats_sent);
        $display("%0d inserts, %0d query hits", inserts, hits);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
